/* sv/vgf_pkg.sv */
// ============================================================================
// vgf_pkg: shared types and codes for the VAR/GARCH variance filter
// Request and coefficient codes, sequencer states, the matrix regions of the
// coefficient store and the 32-bit clamp used by every sum of the datapath.
// ============================================================================
`default_nettype none

package vgf_pkg;

    // Width of the exact sums; products are at most 2^62 before the shift.
    localparam int ACC_W  = 64;
    localparam int DATA_W = 32;

    // Request codes carried by req_type.
    typedef enum logic [1:0] {
        REQ_SAMPLE  = 2'd0,
        REQ_COEF    = 2'd1,
        REQ_RESTART = 2'd2
    } req_t;

    // Coefficient targets carried by coef_kind.
    typedef enum logic [2:0] {
        KIND_MEAN  = 3'd0,
        KIND_CONST = 3'd1,
        KIND_AR    = 3'd2,
        KIND_ARCH  = 3'd3,
        KIND_GARCH = 3'd4
    } kind_t;

    // Regions of the coefficient store, also the order of the term sweep.
    typedef enum logic [1:0] {
        MTX_AR    = 2'd0,
        MTX_ARCH  = 2'd1,
        MTX_GARCH = 2'd2
    } mtx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_SQ,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic                     flag;
        logic signed [DATA_W-1:0] data;
    } sat_t;

    // Clamp an exact sum to the signed 32-bit range and flag the clamp.
    function automatic sat_t sat32(input logic signed [ACC_W-1:0] v);
        sat_t r;
        if (v > ACC_W'(64'sh0000_0000_7FFF_FFFF)) begin
            r.flag = 1'b1;
            r.data = 32'sh7FFF_FFFF;
        end else if (v < -ACC_W'(64'sh0000_0000_8000_0000)) begin
            r.flag = 1'b1;
            r.data = 32'sh8000_0000;
        end else begin
            r.flag = 1'b0;
            r.data = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/vgf_coef_mem.sv */
// ============================================================================
// vgf_coef_mem: coefficient store for the AR, ARCH and GARCH matrices
// One write port, one registered read port. A valid bit per entry, cleared by
// reset, makes an entry that was never written read as zero.
// ============================================================================
`default_nettype none

module vgf_coef_mem
    import vgf_pkg::*;
#(
    parameter int DEPTH = 48,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     wr_en,
    input  wire logic [AW-1:0]            wr_addr,
    input  wire logic signed [DATA_W-1:0] wr_data,
    input  wire logic [AW-1:0]            rd_addr,
    output logic signed [DATA_W-1:0]      rd_data
);

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]         vld_reg;
    logic signed [DATA_W-1:0] rd_data_reg;
    logic                     rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    // Mask entries never written.
    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

/* sv/var_garch_variance_filter_top.sv */
// ============================================================================
// var_garch_variance_filter_top: VAR(1) mean with GARCH(1,1) variance filter
// Per-component conditional variance and residual over a vector time series.
// ============================================================================
// A request transaction is a coefficient write, a restart or one sample
// component. Coefficient writes and restarts give no result. One 32x32
// multiplier is shared by the 3*NUM_DIMS matrix terms of a sample, which
// stream through coefficient read, multiply and accumulate at one term per
// cycle, and then by the squaring of the residual; req_stall stays high
// for the whole sample. The result sits in an output register, so the next
// request is taken while it waits; a sample that finishes while the
// register is still full waits for it to drain. Arithmetic is signed fixed
// point with FRAC_BITS fraction bits; products are floored, every sum is
// exact and clamped once to 32 bits, and a clamp during a sample raises
// saturated.
// ============================================================================
`default_nettype none

module var_garch_variance_filter_top
    import vgf_pkg::*;
#(
    parameter int NUM_DIMS  = 4,
    parameter int FRAC_BITS = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // request channel
    input  wire logic                     req_valid,
    output logic                          req_stall,
    input  wire logic [1:0]               req_type,
    input  wire logic [2:0]               coef_kind,
    input  wire logic [1:0]               coef_row,
    input  wire logic [1:0]               coef_col,
    input  wire logic signed [DATA_W-1:0] value,
    // result channel
    output logic                          res_valid,
    input  wire logic                     res_stall,
    output logic [1:0]                    component,
    output logic signed [DATA_W-1:0]      cond_variance,
    output logic signed [DATA_W-1:0]      residual,
    output logic                          vector_done,
    output logic                          saturated
);

    localparam int NSQ       = NUM_DIMS * NUM_DIMS;
    localparam int MEM_DEPTH = 3 * NSQ;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int IDX_W     = (NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_DIMS - 1);

    // ------------------------------------------------------------------
    // Architectural state
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] mean_vec_reg    [NUM_DIMS];
    logic signed [DATA_W-1:0] const_vec_reg   [NUM_DIMS];
    logic signed [DATA_W-1:0] prev_eps_sq_reg [NUM_DIMS];
    logic signed [DATA_W-1:0] prev_var_reg    [NUM_DIMS];
    logic signed [DATA_W-1:0] prev_dev_reg    [NUM_DIMS];
    logic signed [DATA_W-1:0] next_eps_sq_reg [NUM_DIMS];
    logic signed [DATA_W-1:0] next_var_reg    [NUM_DIMS];
    logic signed [DATA_W-1:0] next_dev_reg    [NUM_DIMS];
    logic [IDX_W-1:0]         comp_count_reg;

    // ------------------------------------------------------------------
    // Sequencer and datapath
    // ------------------------------------------------------------------
    state_t state_reg, state_next;

    mtx_t             typ_reg;       // matrix of the term being issued
    logic [IDX_W-1:0] k_reg;         // column of the term being issued
    logic             issue;
    logic             issue_last;

    // read/multiply stage
    logic                     vb_reg;
    mtx_t                     tag_b_reg;
    logic signed [DATA_W-1:0] opb_b_reg;
    // accumulate stage
    logic                     vc_reg;
    mtx_t                     tag_c_reg;
    logic signed [ACC_W-1:0]  prod_reg;

    logic signed [ACC_W-1:0]  hsum_reg;
    logic signed [ACC_W-1:0]  esum_reg;
    logic signed [DATA_W-1:0] h_reg;
    logic signed [DATA_W-1:0] eps_reg;
    logic signed [DATA_W-1:0] dev_reg;
    logic                     sat_reg;

    logic                     res_valid_reg;
    logic [1:0]               component_reg;
    logic signed [DATA_W-1:0] cond_variance_reg;
    logic signed [DATA_W-1:0] residual_reg;
    logic                     vector_done_reg;
    logic                     saturated_reg;

    logic                     accept;
    logic                     sample_go;
    logic                     restart_go;
    logic                     coef_go;
    logic                     row_ok;
    logic                     col_ok;
    logic                     drained;
    logic                     fin_go;
    logic                     last_comp;
    logic [IDX_W-1:0]         row_idx;

    logic signed [DATA_W-1:0] mean_j;
    logic signed [DATA_W-1:0] const_j;
    logic signed [DATA_W-1:0] opb_sel;
    logic signed [DATA_W-1:0] coef_rd;
    logic signed [DATA_W-1:0] mul_a;
    logic signed [DATA_W-1:0] mul_b;
    logic signed [ACC_W-1:0]  prod_next;
    logic signed [ACC_W-1:0]  term;
    logic signed [ACC_W-1:0]  diff;
    sat_t                     dev_sat;
    sat_t                     h_sat;
    sat_t                     eps_sat;
    sat_t                     epsq_sat;
    sat_t                     rst_dev_sat [NUM_DIMS];

    logic                     mem_wr_en;
    logic [AW-1:0]            mem_wr_addr;
    logic [AW-1:0]            mem_rd_addr;
    mtx_t                     wr_mtx;
    logic                     wr_mtx_ok;

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    assign req_stall  = (state_reg != ST_IDLE);
    assign accept     = req_valid && !req_stall;
    assign sample_go  = accept && (req_type == REQ_SAMPLE);
    assign restart_go = accept && (req_type == REQ_RESTART);
    assign coef_go    = accept && (req_type == REQ_COEF);
    assign row_ok     = (32'(coef_row) < NUM_DIMS);
    assign col_ok     = (32'(coef_col) < NUM_DIMS);
    assign row_idx    = IDX_W'(coef_row);

    // Map a matrix target onto its region of the coefficient store.
    always_comb
    begin
        wr_mtx    = MTX_AR;
        wr_mtx_ok = 1'b0;
        case (coef_kind)
            KIND_AR:
            begin
                wr_mtx    = MTX_AR;
                wr_mtx_ok = 1'b1;
            end
            KIND_ARCH:
            begin
                wr_mtx    = MTX_ARCH;
                wr_mtx_ok = 1'b1;
            end
            KIND_GARCH:
            begin
                wr_mtx    = MTX_GARCH;
                wr_mtx_ok = 1'b1;
            end
            default:
            begin
                wr_mtx    = MTX_AR;
                wr_mtx_ok = 1'b0;
            end
        endcase
    end

    assign mem_wr_en   = coef_go && row_ok && col_ok && wr_mtx_ok;
    assign mem_wr_addr = AW'(32'(wr_mtx) * NSQ + 32'(coef_row) * NUM_DIMS + 32'(coef_col));
    assign mem_rd_addr = AW'(32'(typ_reg) * NSQ + 32'(comp_count_reg) * NUM_DIMS
                             + 32'(k_reg));

    vgf_coef_mem #(
        .DEPTH (MEM_DEPTH),
        .AW    (AW)
    ) u_coef_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (value),
        .rd_addr (mem_rd_addr),
        .rd_data (coef_rd)
    );

    // ------------------------------------------------------------------
    // Datapath combinational terms
    // ------------------------------------------------------------------
    assign mean_j    = mean_vec_reg[comp_count_reg];
    assign const_j   = const_vec_reg[comp_count_reg];
    assign last_comp = (comp_count_reg == LAST_IDX);
    assign diff      = ACC_W'(value) - ACC_W'(mean_j);
    assign dev_sat   = sat32(diff);

    // Clamped negation of each mean, the seed of the deviations on restart.
    always_comb
    begin
        for (int i = 0; i < NUM_DIMS; i++)
        begin
            rst_dev_sat[i] = sat32(-ACC_W'(mean_vec_reg[i]));
        end
    end

    // Pick the previous-step operand that pairs with the issued coefficient.
    always_comb
    begin
        case (typ_reg)
            MTX_AR:    opb_sel = prev_dev_reg[k_reg];
            MTX_ARCH:  opb_sel = prev_eps_sq_reg[k_reg];
            MTX_GARCH: opb_sel = prev_var_reg[k_reg];
            default:   opb_sel = '0;
        endcase
    end

    // The shared multiplier squares the residual once the terms are done.
    assign mul_a     = (state_reg == ST_SQ) ? eps_reg : coef_rd;
    assign mul_b     = (state_reg == ST_SQ) ? eps_reg : opb_b_reg;
    assign prod_next = ACC_W'(mul_a) * ACC_W'(mul_b);
    assign term      = prod_reg >>> FRAC_BITS;

    assign drained   = !vb_reg && !vc_reg;
    assign h_sat     = sat32(hsum_reg);
    assign eps_sat   = sat32(esum_reg);
    assign epsq_sat  = sat32(term);
    assign fin_go    = (state_reg == ST_FIN) && !(res_valid_reg && res_stall);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        issue      = 1'b0;
        issue_last = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_go)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                issue      = 1'b1;
                issue_last = (typ_reg == MTX_GARCH) && (k_reg == LAST_IDX);
                if (issue_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (drained)
                begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (fin_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control and architectural registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_DIMS; i++)
            begin
                mean_vec_reg[i]    <= '0;
                const_vec_reg[i]   <= '0;
                prev_eps_sq_reg[i] <= '0;
                prev_var_reg[i]    <= '0;
                prev_dev_reg[i]    <= '0;
                next_eps_sq_reg[i] <= '0;
                next_var_reg[i]    <= '0;
                next_dev_reg[i]    <= '0;
            end
            comp_count_reg <= '0;
            typ_reg        <= MTX_AR;
            k_reg          <= '0;
            vb_reg         <= 1'b0;
            vc_reg         <= 1'b0;
            tag_b_reg      <= MTX_AR;
            tag_c_reg      <= MTX_AR;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            // vector coefficients
            if (coef_go && row_ok && (coef_kind == KIND_MEAN))
            begin
                mean_vec_reg[row_idx] <= value;
            end
            if (coef_go && row_ok && (coef_kind == KIND_CONST))
            begin
                const_vec_reg[row_idx] <= value;
            end

            // restart: clear history, seed deviations with minus the mean
            if (restart_go)
            begin
                for (int i = 0; i < NUM_DIMS; i++)
                begin
                    prev_eps_sq_reg[i] <= '0;
                    prev_var_reg[i]    <= '0;
                    prev_dev_reg[i]    <= rst_dev_sat[i].data;
                    next_eps_sq_reg[i] <= '0;
                    next_var_reg[i]    <= '0;
                    next_dev_reg[i]    <= '0;
                end
                comp_count_reg <= '0;
            end

            // term sweep: advance column, then matrix
            if (sample_go)
            begin
                typ_reg <= MTX_AR;
                k_reg   <= '0;
            end
            else if (issue)
            begin
                if (k_reg == LAST_IDX)
                begin
                    k_reg <= '0;
                    case (typ_reg)
                        MTX_AR:  typ_reg <= MTX_ARCH;
                        MTX_ARCH: typ_reg <= MTX_GARCH;
                        default: typ_reg <= MTX_AR;
                    endcase
                end
                else
                begin
                    k_reg <= k_reg + 1'b1;
                end
            end
            vb_reg    <= issue;
            tag_b_reg <= typ_reg;
            vc_reg    <= vb_reg;
            tag_c_reg <= tag_b_reg;

            // retire the component: store new values, advance the step
            if (fin_go)
            begin
                next_var_reg[comp_count_reg]    <= h_reg;
                next_eps_sq_reg[comp_count_reg] <= epsq_sat.data;
                next_dev_reg[comp_count_reg]    <= dev_reg;
                if (last_comp)
                begin
                    for (int i = 0; i < NUM_DIMS; i++)
                    begin
                        if (IDX_W'(i) == comp_count_reg)
                        begin
                            prev_var_reg[i]    <= h_reg;
                            prev_eps_sq_reg[i] <= epsq_sat.data;
                            prev_dev_reg[i]    <= dev_reg;
                        end
                        else
                        begin
                            prev_var_reg[i]    <= next_var_reg[i];
                            prev_eps_sq_reg[i] <= next_eps_sq_reg[i];
                            prev_dev_reg[i]    <= next_dev_reg[i];
                        end
                    end
                    comp_count_reg <= '0;
                end
                else
                begin
                    comp_count_reg <= comp_count_reg + 1'b1;
                end
            end

            // output register: fill on retire, drop on transaction
            if (fin_go)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && !res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        opb_b_reg <= opb_sel;

        if (vb_reg || (state_reg == ST_SQ))
        begin
            prod_reg <= prod_next;
        end

        // seed the sums on acceptance, then fold in one term per cycle
        if (sample_go)
        begin
            hsum_reg <= ACC_W'(const_j);
            esum_reg <= diff;
            dev_reg  <= dev_sat.data;
            sat_reg  <= dev_sat.flag;
        end
        else
        begin
            if (vc_reg)
            begin
                if (tag_c_reg == MTX_AR)
                begin
                    esum_reg <= esum_reg - term;
                end
                else
                begin
                    hsum_reg <= hsum_reg + term;
                end
            end
            if ((state_reg == ST_DRAIN) && drained)
            begin
                h_reg   <= h_sat.data;
                eps_reg <= eps_sat.data;
                sat_reg <= sat_reg | h_sat.flag | eps_sat.flag;
            end
        end

        if (fin_go)
        begin
            component_reg     <= 2'(comp_count_reg);
            cond_variance_reg <= h_reg;
            residual_reg      <= eps_reg;
            vector_done_reg   <= last_comp;
            saturated_reg     <= sat_reg | epsq_sat.flag;
        end
    end

    assign res_valid     = res_valid_reg;
    assign component     = component_reg;
    assign cond_variance = cond_variance_reg;
    assign residual      = residual_reg;
    assign vector_done   = vector_done_reg;
    assign saturated     = saturated_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_res_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(state_reg == ST_FIN))
        else $error("result appeared without a retire");

    a_sq_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQ) |-> (!vb_reg && !vc_reg))
        else $error("squaring while terms still in the multiplier");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(comp_count_reg) < NUM_DIMS)
        else $error("component count out of range");

    a_done_comp: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && vector_done) |-> (32'(component) == ((NUM_DIMS - 1) % 4)))
        else $error("vector_done on a component other than the last");

    a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && (req_type == REQ_SAMPLE)) |=> (state_reg == ST_RUN))
        else $error("accepted sample did not start the term sweep");

endmodule

`default_nettype wire
